### design/gpc_pkg.sv
`timescale 1ns / 1ps

package gpc_pkg;

    localparam int PIN_COUNT_DEF = 58;
    localparam int PAD_W         = 58;
    localparam int CMD_W         = 5;
    localparam int PIN_W         = 6;
    localparam int ARG_W         = 8;
    localparam int RV_W          = 3;
    localparam int FUNC_W        = 3;
    localparam int PULL_W        = 2;
    localparam int EN_W          = 6;
    localparam int MAX_PINS      = 2 ** PIN_W;

    // detect enable bit positions
    localparam int EN_RISE  = 0;
    localparam int EN_FALL  = 1;
    localparam int EN_ARISE = 2;
    localparam int EN_AFALL = 3;
    localparam int EN_HIGH  = 4;
    localparam int EN_LOW   = 5;

    localparam logic [CMD_W-1:0] CMD_RESET_PIN = 5'd0;
    localparam logic [CMD_W-1:0] CMD_SET_LEVEL = 5'd1;
    localparam logic [CMD_W-1:0] CMD_GET_LEVEL = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SET_MODE  = 5'd3;
    localparam logic [CMD_W-1:0] CMD_GET_MODE  = 5'd4;
    localparam logic [CMD_W-1:0] CMD_SET_PULL  = 5'd5;
    localparam logic [CMD_W-1:0] CMD_GET_PULL  = 5'd6;
    localparam logic [CMD_W-1:0] CMD_GET_EVENT = 5'd7;
    localparam logic [CMD_W-1:0] CMD_SET_RISE  = 5'd8;
    localparam logic [CMD_W-1:0] CMD_GET_RISE  = 5'd9;
    localparam logic [CMD_W-1:0] CMD_SET_FALL  = 5'd10;
    localparam logic [CMD_W-1:0] CMD_GET_FALL  = 5'd11;
    localparam logic [CMD_W-1:0] CMD_SET_ARISE = 5'd12;
    localparam logic [CMD_W-1:0] CMD_GET_ARISE = 5'd13;
    localparam logic [CMD_W-1:0] CMD_SET_AFALL = 5'd14;
    localparam logic [CMD_W-1:0] CMD_GET_AFALL = 5'd15;
    localparam logic [CMD_W-1:0] CMD_SET_HIGH  = 5'd16;
    localparam logic [CMD_W-1:0] CMD_GET_HIGH  = 5'd17;
    localparam logic [CMD_W-1:0] CMD_SET_LOW   = 5'd18;
    localparam logic [CMD_W-1:0] CMD_GET_LOW   = 5'd19;
    localparam logic [CMD_W-1:0] CMD_SAMPLE    = 5'd20;

    // detect enable set/get pair index (command code shifted right by one) of the first pair
    localparam logic [CMD_W-2:0] EN_PAIR_BASE = 4'd4;

    typedef struct packed {
        logic exec;
    } t_dp_cmd;

endpackage

### design/gpc_ctrl.sv
`timescale 1ns / 1ps

module gpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output gpc_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_EMPTY = 2'b01,
        S_FULL  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // a waiting result blocks new requests only while the receiver stalls
    assign o_stall    = (r_state == S_FULL) && i_stall;
    assign accept     = i_valid && !o_stall;
    assign o_valid    = (r_state == S_FULL);
    assign o_cmd.exec = accept;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EMPTY: begin
                if (accept) n_state = S_FULL;
            end
            S_FULL: begin
                if (accept)        n_state = S_FULL;
                else if (!i_stall) n_state = S_EMPTY;
            end
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/gpc_datapath.sv
`timescale 1ns / 1ps

module gpc_datapath #(
    parameter int PIN_COUNT = gpc_pkg::PIN_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gpc_pkg::t_dp_cmd            i_cmd,
    input  logic [gpc_pkg::CMD_W-1:0]   i_command,
    input  logic [gpc_pkg::PIN_W-1:0]   i_pin,
    input  logic [gpc_pkg::ARG_W-1:0]   i_argument,
    input  logic [gpc_pkg::PAD_W-1:0]   i_pad_levels,
    output logic [gpc_pkg::RV_W-1:0]    o_read_value,
    output logic [gpc_pkg::PAD_W-1:0]   o_output_levels
);

    localparam int IDX_W     = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam int PIN_CMP_W = gpc_pkg::PIN_W + 1;
    localparam int MAXP      = gpc_pkg::MAX_PINS;
    localparam logic [MAXP-1:0] PINS_MASK =
        (PIN_COUNT >= MAXP) ? {MAXP{1'b1}} : ((MAXP'(1) << PIN_COUNT) - MAXP'(1));

    logic [gpc_pkg::FUNC_W-1:0] r_func   [PIN_COUNT];
    logic [gpc_pkg::PULL_W-1:0] r_pull   [PIN_COUNT];
    logic [gpc_pkg::EN_W-1:0]   r_en     [PIN_COUNT];
    logic [PIN_COUNT-1:0]       r_latch;
    logic [PIN_COUNT-1:0]       r_event;
    logic [gpc_pkg::PAD_W-1:0]  r_last_pads;
    logic [gpc_pkg::RV_W-1:0]   r_read_value;
    logic [gpc_pkg::RV_W-1:0]   n_read_value;

    logic                       pin_ok;
    logic [IDX_W-1:0]           idx;
    logic [gpc_pkg::CMD_W-2:0]  pair;
    logic [2:0]                 en_sel;
    logic                       lvl;
    logic [gpc_pkg::PAD_W-1:0]  pad_now;
    logic [MAXP-1:0]            now_ext;
    logic [MAXP-1:0]            last_ext;
    logic [MAXP-1:0]            latch_ext;
    logic [PIN_COUNT-1:0]       hit;

    assign pin_ok  = PIN_CMP_W'(i_pin) < PIN_CMP_W'(PIN_COUNT);
    assign idx     = i_pin[IDX_W-1:0];
    assign pair    = i_command[gpc_pkg::CMD_W-1:1] - gpc_pkg::EN_PAIR_BASE;
    assign en_sel  = pair[2:0];
    assign lvl     = (i_pin < gpc_pkg::PIN_W'(gpc_pkg::PAD_W)) ? r_last_pads[i_pin] : 1'b0;
    assign pad_now = i_pad_levels & PINS_MASK[gpc_pkg::PAD_W-1:0];

    assign now_ext   = MAXP'(pad_now);
    assign last_ext  = MAXP'(r_last_pads);
    assign latch_ext = MAXP'(r_latch);

    // edge and level detects, async edges act as sync edges
    always_comb begin
        for (int i = 0; i < PIN_COUNT; i++) begin
            hit[i] = (!last_ext[i] && now_ext[i]
                         && (r_en[i][gpc_pkg::EN_RISE] || r_en[i][gpc_pkg::EN_ARISE]))
                  || (last_ext[i] && !now_ext[i]
                         && (r_en[i][gpc_pkg::EN_FALL] || r_en[i][gpc_pkg::EN_AFALL]))
                  || (now_ext[i] && r_en[i][gpc_pkg::EN_HIGH])
                  || (!now_ext[i] && r_en[i][gpc_pkg::EN_LOW]);
        end
    end

    always_comb begin
        n_read_value = '0;
        if (pin_ok) begin
            unique case (i_command)
                gpc_pkg::CMD_GET_LEVEL: n_read_value = gpc_pkg::RV_W'(lvl);
                gpc_pkg::CMD_GET_MODE:  n_read_value = r_func[idx];
                gpc_pkg::CMD_GET_PULL:  n_read_value = gpc_pkg::RV_W'(r_pull[idx]);
                gpc_pkg::CMD_GET_EVENT: n_read_value = gpc_pkg::RV_W'(r_event[idx]);
                gpc_pkg::CMD_GET_RISE, gpc_pkg::CMD_GET_FALL,
                gpc_pkg::CMD_GET_ARISE, gpc_pkg::CMD_GET_AFALL,
                gpc_pkg::CMD_GET_HIGH, gpc_pkg::CMD_GET_LOW:
                    n_read_value = gpc_pkg::RV_W'(r_en[idx][en_sel]);
                default: n_read_value = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_func[i] <= '0;
                r_pull[i] <= '0;
                r_en[i]   <= '0;
            end
            r_latch     <= '0;
            r_event     <= '0;
            r_last_pads <= '0;
        end else if (i_cmd.exec) begin
            if (i_command == gpc_pkg::CMD_SAMPLE) begin
                r_event     <= r_event | hit;
                r_last_pads <= pad_now;
            end else if (pin_ok) begin
                unique case (i_command)
                    gpc_pkg::CMD_RESET_PIN: begin
                        r_func[idx]  <= '0;
                        r_pull[idx]  <= '0;
                        r_en[idx]    <= '0;
                        r_event[idx] <= 1'b0;
                    end
                    gpc_pkg::CMD_SET_LEVEL: r_latch[idx] <= i_argument[0];
                    gpc_pkg::CMD_SET_MODE:  r_func[idx]  <= i_argument[gpc_pkg::FUNC_W-1:0];
                    gpc_pkg::CMD_SET_PULL:  r_pull[idx]  <= i_argument[gpc_pkg::PULL_W-1:0];
                    gpc_pkg::CMD_SET_RISE, gpc_pkg::CMD_SET_FALL,
                    gpc_pkg::CMD_SET_ARISE, gpc_pkg::CMD_SET_AFALL,
                    gpc_pkg::CMD_SET_HIGH, gpc_pkg::CMD_SET_LOW:
                        r_en[idx][en_sel] <= i_argument[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_read_value <= n_read_value;
        end
    end

    assign o_read_value    = r_read_value;
    assign o_output_levels = latch_ext[gpc_pkg::PAD_W-1:0];

endmodule

### design/gpio_pin_command_controller.sv
`timescale 1ns / 1ps
// per-pin gpio controller driven by command requests
// input channel: i_valid / o_stall with i_command, i_pin, i_argument and
//   i_pad_levels; a request is taken at a clock edge with i_valid high and
//   o_stall low
// output channel: o_valid / i_stall with o_read_value and o_output_levels;
//   one result per request, taken when o_valid is high and i_stall is low
// the result is registered and shows in the cycle after its request is taken
// throughput: one request per cycle unless stalled; all per-pin fields sit
//   in flops and one command touches one pin (all pins for a pad sample)
// the result register frees up in the same cycle it is taken, so a new
//   request enters while the old result leaves
// when the receiver stalls, the result holds and o_stall goes high until
//   the result is taken
// reset (i_rst_n low, synchronous) clears every pin to input mode, no pull,
//   detects off, latch and event low, and clears the latched pad levels
// pins at or above PIN_COUNT ignore set commands and read as zero
module gpio_pin_command_controller #(
    parameter int PIN_COUNT = gpc_pkg::PIN_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [gpc_pkg::CMD_W-1:0]   i_command,
    input  logic [gpc_pkg::PIN_W-1:0]   i_pin,
    input  logic [gpc_pkg::ARG_W-1:0]   i_argument,
    input  logic [gpc_pkg::PAD_W-1:0]   i_pad_levels,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [gpc_pkg::RV_W-1:0]    o_read_value,
    output logic [gpc_pkg::PAD_W-1:0]   o_output_levels
);

    gpc_pkg::t_dp_cmd dp_cmd;

    gpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd)
    );

    gpc_datapath #(
        .PIN_COUNT (PIN_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_command       (i_command),
        .i_pin           (i_pin),
        .i_argument      (i_argument),
        .i_pad_levels    (i_pad_levels),
        .o_read_value    (o_read_value),
        .o_output_levels (o_output_levels)
    );

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("taken request produced no result");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_value)
                                  && $stable(o_output_levels)))
        else $error("stalled result changed");

    a_sample_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_command == gpc_pkg::CMD_SAMPLE) |=> (o_read_value == '0))
        else $error("sample command returned nonzero read value");

    a_unused_pins_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (PIN_COUNT >= gpc_pkg::PAD_W) || ((o_output_levels >> PIN_COUNT) == '0))
        else $error("output level set on a pin beyond the pin count");
`endif

endmodule
